/* src/eda_pkg.sv */
// ----------------------------------------------------------------------------
// eda_pkg: shared types and constants for the encoder detent acceleration block
// Transaction payloads, configuration register map and direction codes.
// ----------------------------------------------------------------------------
package eda_pkg;

    // Field widths, fixed by the transaction formats
    localparam int DELTA_W    = 16;
    localparam int INDEX_W    = 4;
    localparam int NOW_W      = 32;
    localparam int BASE_W     = 8;
    localparam int MULT_W     = 12;
    localparam int SCALED_W   = 28;
    localparam int CLASSES_W  = 16;
    localparam int PAUSE_W    = 16;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CLASSES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SMALL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_MEDIUM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LARGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MULT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_MS      = 3'd5;

    // Configuration reset values
    localparam logic [CLASSES_W-1:0] RST_RANGE_CLASSES = 16'd0;
    localparam logic [BASE_W-1:0]    RST_BASE_SMALL    = 8'd5;
    localparam logic [BASE_W-1:0]    RST_BASE_MEDIUM   = 8'd7;
    localparam logic [BASE_W-1:0]    RST_BASE_LARGE    = 8'd12;
    localparam logic [MULT_W-1:0]    RST_MAX_MULT      = 12'd50;
    localparam logic [PAUSE_W-1:0]   RST_PAUSE_MS      = 16'd500;

    // Turning direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    // Range class codes (3 also means large)
    localparam logic [1:0] CLASS_SMALL  = 2'd0;
    localparam logic [1:0] CLASS_MEDIUM = 2'd1;

    // Item kinds
    localparam logic KIND_DELTA  = 1'b0;
    localparam logic KIND_SWITCH = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam logic [MULT_W-1:0]  MULT_ONE  = 12'd1;

    typedef struct packed {
        logic                       kind;
        logic [INDEX_W-1:0]         encoder_index;
        logic signed [DELTA_W-1:0]  delta;
        logic [NOW_W-1:0]           now_ms;
        logic                       switch_on;
    } in_item_t;

    typedef struct packed {
        logic signed [SCALED_W-1:0] scaled_delta;
        logic [MULT_W-1:0]          applied_multiplier;
    } out_item_t;

    typedef struct packed {
        logic [CLASSES_W-1:0] range_classes;
        logic [BASE_W-1:0]    base_small;
        logic [BASE_W-1:0]    base_medium;
        logic [BASE_W-1:0]    base_large;
        logic [MULT_W-1:0]    mult_cap;
        logic [PAUSE_W-1:0]   pause_ms;
    } cfg_t;

    // Operands handed from the acceleration logic to the scaling stage
    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic [MULT_W-1:0]         mult;
    } accel_res_t;

endpackage

/* src/encoder_detent_acceleration_top.sv */
// ----------------------------------------------------------------------------
// encoder_detent_acceleration_top: rotary encoder delta scaler with detent
// acceleration
// Accepts delta and coarse-switch transactions and returns one result per
// transaction: the delta times the per-encoder multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel (valid/ready) carries input transactions: a delta for one
//   encoder (kind 0) or a coarse mode switch update (kind 1).
//   m_* channel (valid/ready) returns exactly one result per transaction, in
//   order: scaled delta and the multiplier applied.
//   cfg_wr_* is a plain write port; write only while no transaction is in
//   flight. Indexes past the register list are ignored.
// Pipeline:
//   A transaction lands in the input register, is resolved in one pass of
//   state lookup, multiplier select and one 16x12 multiply, and sits in the
//   result register, which drives m_valid. One transaction per cycle is
//   sustained while m_ready stays high; the per-encoder state update is
//   visible to the very next transaction.
// Reset (aresetn low, synchronous): coarse mode off, all encoder state
//   cleared, configuration back to its default values, both channels empty.
// Receiver stall: the result register holds; the input register still takes
//   one more transaction, after which s_ready drops until m_ready returns.
// ----------------------------------------------------------------------------
module encoder_detent_acceleration_top #(
    parameter int NUM_ENCODERS      = 8,
    parameter int DETENTS_PER_LEVEL = 3,
    parameter int MAX_LEVEL         = 4,
    parameter int TIME_WIDTH        = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  eda_pkg::in_item_t                  s_data,

    output logic                               m_valid,
    input  logic                               m_ready,
    output eda_pkg::out_item_t                 m_data,

    input  logic                               cfg_wr_en,
    input  logic [eda_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [eda_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import eda_pkg::*;

    // Input register
    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       advance;
    cfg_t       cfg_reg;
    accel_res_t accel_res;

    // The input register moves to the result register whenever that one is
    // empty or being emptied this cycle.
    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_classes <= RST_RANGE_CLASSES;
            cfg_reg.base_small    <= RST_BASE_SMALL;
            cfg_reg.base_medium   <= RST_BASE_MEDIUM;
            cfg_reg.base_large    <= RST_BASE_LARGE;
            cfg_reg.mult_cap      <= RST_MAX_MULT;
            cfg_reg.pause_ms      <= RST_PAUSE_MS;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_RANGE_CLASSES: cfg_reg.range_classes <= cfg_wr_data[CLASSES_W-1:0];
                CFG_BASE_SMALL:    cfg_reg.base_small    <= cfg_wr_data[BASE_W-1:0];
                CFG_BASE_MEDIUM:   cfg_reg.base_medium   <= cfg_wr_data[BASE_W-1:0];
                CFG_BASE_LARGE:    cfg_reg.base_large    <= cfg_wr_data[BASE_W-1:0];
                CFG_MAX_MULT:      cfg_reg.mult_cap      <= cfg_wr_data[MULT_W-1:0];
                CFG_PAUSE_MS:      cfg_reg.pause_ms      <= cfg_wr_data[PAUSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Per-encoder state and multiplier selection
    eda_accel #(
        .NUM_ENCODERS      (NUM_ENCODERS),
        .DETENTS_PER_LEVEL (DETENTS_PER_LEVEL),
        .MAX_LEVEL         (MAX_LEVEL),
        .TIME_WIDTH        (TIME_WIDTH)
    ) u_accel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (accel_res)
    );

    // Multiply and result register
    eda_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .res     (accel_res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

/* src/eda_accel.sv */
// ----------------------------------------------------------------------------
// eda_accel: per-encoder acceleration state and multiplier selection
// Holds direction, detent run and last activity per encoder; picks the
// multiplier for the item in the input register and updates state on advance.
// ----------------------------------------------------------------------------
module eda_accel #(
    parameter int NUM_ENCODERS      = 8,
    parameter int DETENTS_PER_LEVEL = 3,
    parameter int MAX_LEVEL         = 4,
    parameter int TIME_WIDTH        = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  eda_pkg::in_item_t   item,
    input  eda_pkg::cfg_t       cfg,
    output eda_pkg::accel_res_t res
);
    import eda_pkg::*;

    localparam int IDX_W  = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
    localparam int LVL_W  = (MAX_LEVEL > 0) ? $clog2(MAX_LEVEL + 1) : 1;
    localparam int CMP_W  = ((BASE_W + MAX_LEVEL) > MULT_W) ? (BASE_W + MAX_LEVEL) : MULT_W;

    logic                  coarse_reg;
    logic [1:0]            last_dir_reg [NUM_ENCODERS];
    logic [COUNT_W-1:0]    count_reg    [NUM_ENCODERS];
    logic [TIME_WIDTH-1:0] last_act_reg [NUM_ENCODERS];

    logic                  in_range;
    logic [IDX_W-1:0]      sel;
    logic [1:0]            dir;
    logic [1:0]            cur_dir;
    logic [1:0]            dir_next;
    logic [COUNT_W-1:0]    cur_count;
    logic [COUNT_W-1:0]    count_base;
    logic [COUNT_W-1:0]    count_next;
    logic [TIME_WIDTH-1:0] cur_act;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  paused;
    logic                  dir_flip;
    logic [LVL_W-1:0]      level;
    logic [1:0]            cls;
    logic [BASE_W-1:0]     base;
    logic [CMP_W-1:0]      mult_ext;
    logic [MULT_W-1:0]     mult;

    assign in_range  = ({1'b0, item.encoder_index} < (INDEX_W + 1)'(NUM_ENCODERS));
    assign sel       = item.encoder_index[IDX_W-1:0];
    assign cur_dir   = last_dir_reg[sel];
    assign cur_count = count_reg[sel];
    assign cur_act   = last_act_reg[sel];
    assign now_t     = item.now_ms[TIME_WIDTH-1:0];

    always_comb begin
        if (item.delta > 0) begin
            dir = DIR_POS;
        end else if (item.delta < 0) begin
            dir = DIR_NEG;
        end else begin
            dir = DIR_NONE;
        end
    end

    assign dir_flip = (dir != DIR_NONE) && (cur_dir != DIR_NONE) && (cur_dir != dir);
    assign dir_next = (dir != DIR_NONE) ? dir : cur_dir;
    assign elapsed  = now_t - cur_act;
    assign paused   = (cur_act != '0) && (elapsed > TIME_WIDTH'(cfg.pause_ms));

    always_comb begin
        count_base = (dir_flip || paused) ? '0 : cur_count;
        count_next = count_base;
        if ((dir != DIR_NONE) && (count_base != COUNT_MAX)) begin
            count_next = count_base + 1'b1;
        end
    end

    // level = count / DETENTS_PER_LEVEL capped at MAX_LEVEL, as a threshold chain
    always_comb begin
        level = '0;
        for (int k = 1; k <= MAX_LEVEL; k++) begin
            if (count_next >= COUNT_W'(k * DETENTS_PER_LEVEL)) begin
                level = LVL_W'(k);
            end
        end
    end

    // Encoders past the class register fall back to small
    always_comb begin
        cls = CLASS_SMALL;
        if (item.encoder_index < INDEX_W'(8)) begin
            cls = cfg.range_classes[{item.encoder_index[2:0], 1'b0} +: 2];
        end
    end

    always_comb begin
        case (cls)
            CLASS_SMALL:  base = cfg.base_small;
            CLASS_MEDIUM: base = cfg.base_medium;
            default:      base = cfg.base_large;
        endcase
    end

    assign mult_ext = CMP_W'(base) << level;
    assign mult     = (mult_ext > CMP_W'(cfg.mult_cap)) ? cfg.mult_cap
                                                        : mult_ext[MULT_W-1:0];

    always_comb begin
        res.delta = item.delta;
        res.mult  = MULT_ONE;
        if (item.kind == KIND_SWITCH) begin
            res.delta = '0;
        end else if (in_range && coarse_reg) begin
            res.mult = mult;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coarse_reg <= 1'b0;
            for (int i = 0; i < NUM_ENCODERS; i++) begin
                last_dir_reg[i] <= DIR_NONE;
                count_reg[i]    <= '0;
                last_act_reg[i] <= '0;
            end
        end else if (advance) begin
            if (item.kind == KIND_SWITCH) begin
                if (coarse_reg && !item.switch_on) begin
                    for (int i = 0; i < NUM_ENCODERS; i++) begin
                        last_dir_reg[i] <= DIR_NONE;
                        count_reg[i]    <= '0;
                        last_act_reg[i] <= '0;
                    end
                end
                coarse_reg <= item.switch_on;
            end else if (in_range) begin
                if (!coarse_reg) begin
                    last_dir_reg[sel] <= DIR_NONE;
                    count_reg[sel]    <= '0;
                    last_act_reg[sel] <= '0;
                end else begin
                    last_dir_reg[sel] <= dir_next;
                    count_reg[sel]    <= count_next;
                    if (dir != DIR_NONE) begin
                        last_act_reg[sel] <= now_t;
                    end
                end
            end
        end
    end

endmodule

/* src/eda_out_stage.sv */
// ----------------------------------------------------------------------------
// eda_out_stage: delta scaling multiply and result register
// Multiplies the selected delta by the multiplier and holds the result
// transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module eda_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  eda_pkg::accel_res_t res,
    input  logic                m_ready,
    output logic                m_valid,
    output eda_pkg::out_item_t  m_data
);
    import eda_pkg::*;

    logic                        valid_reg;
    out_item_t                   data_reg;
    logic signed [SCALED_W-1:0]  product;

    // 16 x 12 product always fits the 28-bit result
    assign product = res.delta * $signed({1'b0, res.mult});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg.scaled_delta       <= product;
            data_reg.applied_multiplier <= res.mult;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

/* bench/tb_encoder_detent_acceleration_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_encoder_detent_acceleration_top: self-checking bench for the encoder
// detent acceleration block
// Walks a short directed table, then runs random transactions under several
// register settings. Each accepted transaction is predicted in-bench and every
// result is compared field by field, in order, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb_encoder_detent_acceleration_top;

    import eda_pkg::*;

    localparam int NUM_ENC     = 8;
    localparam int DETENTS_LVL = 3;
    localparam int LEVEL_CAP   = 4;
    localparam int TIME_BITS   = 32;

    // Index past the register list; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;

    localparam int NUM_PHASES = 5;

    typedef struct {
        in_item_t  item;
        bit        typed;   // result below is fixed by hand, not predicted
        out_item_t result;
    } script_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    in_item_t              s_data       = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    // Hand-typed expectation riding along with the transaction on s_data
    logic                  pinned_typed  = 1'b0;
    out_item_t             pinned_result = '0;

    // When set, neither side idles: back-to-back stretches
    bit                    steady = 1'b0;

    always #1 aclk = ~aclk;

    encoder_detent_acceleration_top #(
        .NUM_ENCODERS      (NUM_ENC),
        .DETENTS_PER_LEVEL (DETENTS_LVL),
        .MAX_LEVEL         (LEVEL_CAP),
        .TIME_WIDTH        (TIME_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // Bench copy of the acceleration state and the registers
    // ------------------------------------------------------------------------
    logic                coarse_on;
    logic [1:0]          dir_last  [NUM_ENC];
    logic [COUNT_W-1:0]  run_count [NUM_ENC];
    logic [NOW_W-1:0]    stamp     [NUM_ENC];
    cfg_t                cfg_now;

    out_item_t           expected_results [$];
    int                  mismatches = 0;

    function automatic void forget_encoder(int i);
        dir_last[i]  = DIR_NONE;
        run_count[i] = '0;
        stamp[i]     = '0;
    endfunction

    // Expected result of one transaction; updates the bench state as the
    // block would.
    function automatic out_item_t accelerate(in_item_t it);
        out_item_t        r;
        longint           d;
        logic [1:0]       dir;
        logic [1:0]       cls;
        logic [NOW_W-1:0] idle;
        int               idx;
        int unsigned      lvl;
        int unsigned      base;
        int unsigned      mult;

        r.scaled_delta       = '0;
        r.applied_multiplier = MULT_ONE;

        if (it.kind == KIND_SWITCH) begin
            // Turning coarse mode off wipes every encoder
            if (coarse_on && !it.switch_on) begin
                for (int i = 0; i < NUM_ENC; i++) forget_encoder(i);
            end
            coarse_on = it.switch_on;
            return r;
        end

        d = longint'($signed(it.delta));
        if (it.encoder_index >= NUM_ENC) begin
            r.scaled_delta = SCALED_W'(d);
            return r;
        end

        idx = it.encoder_index;
        if (!coarse_on) begin
            forget_encoder(idx);
            r.scaled_delta = SCALED_W'(d);
            return r;
        end

        dir = (d > 0) ? DIR_POS : ((d < 0) ? DIR_NEG : DIR_NONE);

        if (dir != DIR_NONE) begin
            if (dir_last[idx] != DIR_NONE && dir_last[idx] != dir) run_count[idx] = '0;
            dir_last[idx] = dir;
        end

        // Stamp of zero means never active; difference wraps with the clock
        idle = it.now_ms - stamp[idx];
        if (stamp[idx] != '0 && idle > {{(NOW_W-PAUSE_W){1'b0}}, cfg_now.pause_ms})
            run_count[idx] = '0;

        if (dir != DIR_NONE) begin
            stamp[idx] = it.now_ms;
            if (run_count[idx] != COUNT_MAX) run_count[idx] = run_count[idx] + 1'b1;
        end

        lvl = run_count[idx] / DETENTS_LVL;
        if (lvl > LEVEL_CAP) lvl = LEVEL_CAP;

        cls = cfg_now.range_classes[2*idx +: 2];
        if (cls == CLASS_SMALL)
            base = cfg_now.base_small;
        else if (cls == CLASS_MEDIUM)
            base = cfg_now.base_medium;
        else
            base = cfg_now.base_large;

        mult = base << lvl;
        if (mult > cfg_now.mult_cap) mult = cfg_now.mult_cap;

        r.scaled_delta       = SCALED_W'(d * longint'(mult));
        r.applied_multiplier = MULT_W'(mult);
        return r;
    endfunction

    // One line per mismatch, and a count for the final verdict
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: compare the result transaction first, then predict the input
    // transaction taken at the same edge. Both sample pre-edge values.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        out_item_t want;
        out_item_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (got.scaled_delta !== want.scaled_delta)
                        report_mismatch($sformatf("scaled_delta got %0d want %0d",
                            $signed(got.scaled_delta), $signed(want.scaled_delta)));
                    if (got.applied_multiplier !== want.applied_multiplier)
                        report_mismatch($sformatf("applied_multiplier got %0d want %0d",
                            got.applied_multiplier, want.applied_multiplier));
                end
            end
            if (s_valid && s_ready) begin
                want = accelerate(s_data);
                if (pinned_typed) want = pinned_result;
                expected_results.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall before taking each result
    // ------------------------------------------------------------------------
    initial begin : receiver
        int stall;
        @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers. All are entered and left on a rising edge.
    // ------------------------------------------------------------------------

    // Random gap, then hold the transaction until s_ready takes it
    task automatic push_item(input in_item_t it, input bit typed, input out_item_t res);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data        <= it;
        pinned_typed  <= typed;
        pinned_result <= res;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait out every outstanding result, plus the pipe depth
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One register write; the bench copy follows the same masking
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        case (idx)
            CFG_RANGE_CLASSES: cfg_now.range_classes = val[CLASSES_W-1:0];
            CFG_BASE_SMALL:    cfg_now.base_small    = val[BASE_W-1:0];
            CFG_BASE_MEDIUM:   cfg_now.base_medium   = val[BASE_W-1:0];
            CFG_BASE_LARGE:    cfg_now.base_large    = val[BASE_W-1:0];
            CFG_MAX_MULT:      cfg_now.mult_cap      = val[MULT_W-1:0];
            CFG_PAUSE_MS:      cfg_now.pause_ms      = val[PAUSE_W-1:0];
            default: ;
        endcase
    endtask

    script_row_t script [$];

    task automatic add_row(input logic kind, input int idx, input int delta,
                           input logic [NOW_W-1:0] now, input logic sw,
                           input bit typed, input int scaled, input int mult);
        script_row_t row;
        row.item.kind                 = kind;
        row.item.encoder_index        = INDEX_W'(idx);
        row.item.delta                = DELTA_W'(delta);
        row.item.now_ms               = now;
        row.item.switch_on            = sw;
        row.typed                     = typed;
        row.result.scaled_delta       = SCALED_W'(scaled);
        row.result.applied_multiplier = MULT_W'(mult);
        script.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        cfg_t             settings [NUM_PHASES];
        int               phase_items [NUM_PHASES];
        in_item_t         it;
        logic [NOW_W-1:0] t_now;
        bit               heading [NUM_ENC];   // 1 means turning negative
        bit               coarse_intent;
        int               focus;
        int               streak;
        int               pick;
        int               r;
        int               s;
        int               d;
        int               pz;
        int               step;

        // Bench state starts as the block does after reset
        coarse_on = 1'b0;
        for (int i = 0; i < NUM_ENC; i++) forget_encoder(i);
        cfg_now = '{range_classes: RST_RANGE_CLASSES,
                    base_small:    RST_BASE_SMALL,
                    base_medium:   RST_BASE_MEDIUM,
                    base_large:    RST_BASE_LARGE,
                    mult_cap:      RST_MAX_MULT,
                    pause_ms:      RST_PAUSE_MS};

        // Directed table, run with the reset register values:
        // small class everywhere, base 5, cap 50, pause 500 ms.
        //       kind         idx  delta   now_ms          sw typed scaled mult
        add_row(KIND_DELTA,   0,   100,    32'd10,         0, 1,    100,   1); // coarse off
        add_row(KIND_DELTA,   15,  -32768, 32'hFFFF_FFFF,  1, 1,   -32768, 1); // high index
        add_row(KIND_SWITCH,  9,   32767,  32'hDEAD_BEEF,  0, 1,    0,     1); // off while off
        add_row(KIND_SWITCH,  4,   -1,     32'd123,        1, 1,    0,     1); // on
        add_row(KIND_SWITCH,  0,   0,      32'd0,          1, 1,    0,     1); // on while on
        add_row(KIND_DELTA,   0,   1,      32'd1000,       0, 1,    5,     5); // first detent
        add_row(KIND_DELTA,   0,   1,      32'd1010,       0, 0,    0,     0);
        add_row(KIND_DELTA,   0,   1,      32'd1020,       0, 0,    0,     0); // level 1
        add_row(KIND_DELTA,   0,   0,      32'd1030,       1, 0,    0,     0); // zero delta
        add_row(KIND_DELTA,   0,   -1,     32'd1040,       0, 0,    0,     0); // reversal
        add_row(KIND_DELTA,   0,   -1,     32'd1541,       0, 0,    0,     0); // pause passed
        add_row(KIND_DELTA,   0,   -1,     32'd2041,       0, 0,    0,     0); // pause exact
        add_row(KIND_DELTA,   8,   32767,  32'd2050,       0, 1,    32767, 1); // high index
        add_row(KIND_DELTA,   3,   32767,  32'd0,          0, 0,    0,     0); // stamp at 0
        add_row(KIND_DELTA,   3,   32767,  32'hFFFF_FFFF,  0, 0,    0,     0); // never active
        add_row(KIND_DELTA,   3,   32767,  32'd5,          0, 0,    0,     0); // clock wrap
        add_row(KIND_DELTA,   3,   -32768, 32'd6,          0, 0,    0,     0); // most negative
        add_row(KIND_DELTA,   7,   32767,  32'd100,        0, 0,    0,     0);
        add_row(KIND_SWITCH,  0,   0,      32'd0,          0, 1,    0,     1); // off clears all
        add_row(KIND_DELTA,   0,   5,      32'd3000,       0, 1,    5,     1); // coarse off
        add_row(KIND_SWITCH,  0,   0,      32'd0,          1, 1,    0,     1);
        add_row(KIND_DELTA,   0,   1,      32'd3010,       0, 0,    0,     0); // fresh run
        add_row(KIND_DELTA,   3,   1,      32'd3020,       0, 0,    0,     0); // fresh run

        // Register settings per phase: mixed, all-high, all-low, zero base,
        // and a random one filled in later.
        settings[0] = '{16'hE4E4, 8'd5,   8'd7,   8'd12,  12'd4095, 16'd500};
        settings[1] = '{16'hFFFF, 8'd255, 8'd255, 8'd255, 12'd4095, 16'd65535};
        settings[2] = '{16'h0000, 8'd1,   8'd1,   8'd1,   12'd1,    16'd0};
        settings[3] = '{16'h5A5A, 8'd0,   8'd128, 8'd64,  12'd1000, 16'd20};
        settings[4] = '{CLASSES_W'($urandom), BASE_W'($urandom_range(1, 255)),
                        BASE_W'($urandom_range(1, 255)), BASE_W'($urandom_range(1, 255)),
                        MULT_W'($urandom_range(1, 4095)), PAUSE_W'($urandom_range(0, 100))};
        // Phase 0 carries a long one-way run that drives the count to 255
        phase_items = '{390, 90, 90, 90, 90};

        // Reset: held low from time zero, released once
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[k]) push_item(script[k].item, script[k].typed, script[k].result);

        t_now         = 32'd3100;
        coarse_intent = 1'b1;
        focus         = 0;
        streak        = 0;
        foreach (heading[i]) heading[i] = 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Registers change only with the pipe empty
            drain_results();
            write_reg(CFG_RANGE_CLASSES, CFG_DATA_W'(settings[ph].range_classes));
            write_reg(CFG_BASE_SMALL,    CFG_DATA_W'(settings[ph].base_small));
            write_reg(CFG_BASE_MEDIUM,   CFG_DATA_W'(settings[ph].base_medium));
            write_reg(CFG_BASE_LARGE,    CFG_DATA_W'(settings[ph].base_large));
            write_reg(CFG_MAX_MULT,      CFG_DATA_W'(settings[ph].mult_cap));
            write_reg(CFG_PAUSE_MS,      CFG_DATA_W'(settings[ph].pause_ms));
            if (ph == 1) write_reg(CFG_UNUSED, 16'hFFFF);
            cfg_wr_en <= 1'b0;
            @(posedge aclk);

            if (ph == 0) streak = 300;
            pz = cfg_now.pause_ms;

            for (int n = 0; n < phase_items[ph]; n++) begin
                // Every third stretch of 30 transactions runs without idling
                steady = ((n / 30) % 3 == 2);
                // Sender holds off mid-phase until every result is back
                if (n == 45) drain_results();

                // Noise in every field by default
                it.kind          = KIND_DELTA;
                it.encoder_index = INDEX_W'($urandom);
                it.delta         = DELTA_W'($urandom);
                it.now_ms        = $urandom;
                it.switch_on     = 1'($urandom_range(0, 1));

                pick = (streak > 0) ? 99 : $urandom_range(0, 99);
                if (!coarse_intent && (streak > 0 || $urandom_range(0, 2) == 0)) pick = 0;

                if (pick < 5) begin
                    // Switch transaction; other fields are don't-care
                    it.kind      = KIND_SWITCH;
                    it.switch_on = (pick == 0 && !coarse_intent) ? 1'b1
                                                                 : ($urandom_range(0, 9) < 6);
                    coarse_intent = it.switch_on;
                end else if (pick < 10) begin
                    it.encoder_index = INDEX_W'($urandom_range(NUM_ENC, 15));
                    it.now_ms        = t_now;
                end else if (pick >= 15) begin
                    // Well-formed detent on the focus encoder
                    if (streak > 0) begin
                        streak--;
                    end else begin
                        if ($urandom_range(0, 99) < 4) streak = $urandom_range(10, 20);
                        if ($urandom_range(0, 99) < 8) focus = $urandom_range(0, NUM_ENC - 1);
                        if ($urandom_range(0, 99) < 6) heading[focus] = ~heading[focus];
                    end

                    r = $urandom_range(0, 99);
                    if (r < 5)
                        d = 0;
                    else if (r < 85)
                        d = $urandom_range(1, 4);
                    else if (r < 97)
                        d = $urandom_range(1, 32767);
                    else
                        d = 32767;
                    if (heading[focus]) d = (r >= 97) ? -32768 : -d;

                    // Time step: mostly inside the pause, some at and past it,
                    // now and then a jump to just before the wrap or to zero
                    s = $urandom_range(0, 99);
                    if (streak > 0 || s < 75) begin
                        step = $urandom_range(0, (pz < 40) ? pz : pz / 8);
                    end else if (s < 82) begin
                        step = pz;
                    end else if (s < 88) begin
                        step = pz + 1;
                    end else if (s < 95) begin
                        step = $urandom_range(0, 3 * pz + 3);
                    end else begin
                        step  = 0;
                        t_now = (s == 99) ? '0 : 32'hFFFF_FFFF - $urandom_range(0, 40);
                    end
                    t_now = t_now + NOW_W'(step);

                    it.encoder_index = INDEX_W'(focus);
                    it.delta         = DELTA_W'(d);
                    it.now_ms        = t_now;
                end
                // picks 10..14 stay pure noise

                push_item(it, 1'b0, '0);
            end
        end

        drain_results();
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
src/eda_pkg.sv
src/eda_accel.sv
src/eda_out_stage.sv
src/encoder_detent_acceleration_top.sv
bench/tb_encoder_detent_acceleration_top.sv
